FILE: hdl/two_stage_phase_unwrapper_assert.svh
// Assertion macros used by the phase unwrapper queue (pup_fifo).
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef TWO_STAGE_PHASE_UNWRAPPER_ASSERT_SVH
`define TWO_STAGE_PHASE_UNWRAPPER_ASSERT_SVH

// condition that holds on every clock edge out of reset
`define PUP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define PUP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/pup_pkg.sv
// Shared types and constants of the two-stage phase unwrapper.
// No dependencies; imported by every module of the block but pup_fifo.
package pup_pkg;

  // threshold register width and result width
  localparam int THR_BITS     = 13;
  localparam int OUT_BITS     = 32;
  localparam int CFG_IDX_BITS = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDE_THR   = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_NARROW_THR = 1'b1;

  // reset values: 1.5 pi and 0.5 pi in 1/4096 turn
  localparam logic [THR_BITS-1:0] WIDE_THR_RST   = 13'd3072;
  localparam logic [THR_BITS-1:0] NARROW_THR_RST = 13'd1024;

  typedef struct packed {
    logic [THR_BITS-1:0] wide_thr;
    logic [THR_BITS-1:0] narrow_thr;
  } pup_cfg_t;

endpackage

FILE: hdl/pup_fifo.sv
// Small flop-based queue used between the front and back and at the output.
// Depends on the assertion macro header.
`include "two_stage_phase_unwrapper_assert.svh"

module pup_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push_acc;
  logic             pop_acc;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign push_acc = push && !full;
  assign pop_acc  = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_acc) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop_acc) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push_acc && !pop_acc) begin
      count_nxt = count_r + CW'(1);
    end else if (pop_acc && !push_acc) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (push_acc) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `PUP_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(DEPTH), "fifo count above depth")
  `PUP_ASSERT_NEXT(a_count_up, push_acc && !pop_acc, count_r == $past(count_r) + CW'(1), "fifo count did not rise on push")
  `PUP_ASSERT_NEXT(a_count_down, pop_acc && !push_acc, count_r == $past(count_r) - CW'(1), "fifo count did not fall on pop")

endmodule

FILE: hdl/pup_front.sv
// Front end: mirrors each phase code and runs the full-turn unwrap stage.
// Depends on pup_pkg.
module pup_front
  import pup_pkg::*;
#(
  parameter int PHASE_BITS = 12,
  parameter int ACC_BITS   = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic [PHASE_BITS-1:0]     phase_code,
  input  logic                      first_sample,
  input  logic [THR_BITS-1:0]       wide_thr,
  output logic signed [ACC_BITS-1:0] stage_one
);

  // difference width and pre-clamp sum width
  localparam int D1W = (PHASE_BITS + 2 > THR_BITS + 1) ? PHASE_BITS + 2 : THR_BITS + 1;
  localparam int S1W = ((ACC_BITS > D1W) ? ACC_BITS : D1W) + 2;

  localparam logic signed [S1W-1:0] TURN =
    {{(S1W-PHASE_BITS-1){1'b0}}, 1'b1, {PHASE_BITS{1'b0}}};
  localparam logic signed [S1W-1:0] A_MAX =
    S1W'($signed({1'b0, {(ACC_BITS-1){1'b1}}}));
  localparam logic signed [S1W-1:0] A_MIN =
    S1W'($signed({1'b1, {(ACC_BITS-1){1'b0}}}));

  logic [PHASE_BITS:0]          mirrored;
  logic [PHASE_BITS:0]          prev_m_r;
  logic signed [ACC_BITS-1:0]   acc_r;
  logic signed [D1W-1:0]        m_s;
  logic signed [D1W-1:0]        diff;
  logic signed [D1W-1:0]        thr_s;
  logic signed [S1W-1:0]        sum;
  logic signed [ACC_BITS-1:0]   s1;

  // mirror: one full turn minus the code
  assign mirrored = {1'b1, {PHASE_BITS{1'b0}}} - {1'b0, phase_code};
  assign m_s      = D1W'($signed({1'b0, mirrored}));
  assign diff     = m_s - D1W'($signed({1'b0, prev_m_r}));
  assign thr_s    = D1W'($signed({1'b0, wide_thr}));

  // full-turn correction and saturation
  always_comb begin
    if (first_sample) begin
      sum = S1W'(m_s);
    end else if (diff > thr_s) begin
      sum = S1W'(acc_r) + S1W'(diff) - TURN;
    end else if (diff < -thr_s) begin
      sum = S1W'(acc_r) + S1W'(diff) + TURN;
    end else begin
      sum = S1W'(acc_r) + S1W'(diff);
    end
    if (sum > A_MAX) begin
      s1 = A_MAX[ACC_BITS-1:0];
    end else if (sum < A_MIN) begin
      s1 = A_MIN[ACC_BITS-1:0];
    end else begin
      s1 = sum[ACC_BITS-1:0];
    end
  end

  assign stage_one = s1;

  // stage-one state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_m_r <= '0;
      acc_r    <= '0;
    end else if (accept) begin
      prev_m_r <= mirrored;
      acc_r    <= s1;
    end
  end

endmodule

FILE: hdl/pup_back.sv
// Back end: half-turn unwrap stage on stage-one values and output saturation.
// Depends on pup_pkg.
module pup_back
  import pup_pkg::*;
#(
  parameter int PHASE_BITS = 12,
  parameter int ACC_BITS   = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic signed [ACC_BITS-1:0] stage_one,
  input  logic                       first_sample,
  input  logic [THR_BITS-1:0]        narrow_thr,
  output logic signed [OUT_BITS-1:0] result
);

  localparam int D2W = ACC_BITS + 1;
  localparam int S2W = ACC_BITS + 3;
  localparam int OW  = (ACC_BITS > OUT_BITS) ? ACC_BITS : OUT_BITS;

  localparam logic signed [S2W-1:0] HALF =
    {{(S2W-PHASE_BITS){1'b0}}, 1'b1, {(PHASE_BITS-1){1'b0}}};
  localparam logic signed [S2W-1:0] A_MAX =
    S2W'($signed({1'b0, {(ACC_BITS-1){1'b1}}}));
  localparam logic signed [S2W-1:0] A_MIN =
    S2W'($signed({1'b1, {(ACC_BITS-1){1'b0}}}));
  localparam logic signed [OW-1:0] O_MAX =
    OW'($signed({1'b0, {(OUT_BITS-1){1'b1}}}));
  localparam logic signed [OW-1:0] O_MIN =
    OW'($signed({1'b1, {(OUT_BITS-1){1'b0}}}));

  logic signed [ACC_BITS-1:0] prev_s1_r;
  logic signed [ACC_BITS-1:0] acc_r;
  logic signed [D2W-1:0]      diff;
  logic signed [D2W-1:0]      thr_s;
  logic signed [S2W-1:0]      sum;
  logic signed [ACC_BITS-1:0] s2;
  logic signed [OW-1:0]       s2_ext;

  assign diff  = D2W'(stage_one) - D2W'(prev_s1_r);
  assign thr_s = D2W'($signed({1'b0, narrow_thr}));

  // half-turn correction and accumulator saturation
  always_comb begin
    if (diff > thr_s) begin
      sum = S2W'(acc_r) + S2W'(diff) - HALF;
    end else if (diff < -thr_s) begin
      sum = S2W'(acc_r) + S2W'(diff) + HALF;
    end else begin
      sum = S2W'(acc_r) + S2W'(diff);
    end
    if (first_sample) begin
      s2 = stage_one;
    end else if (sum > A_MAX) begin
      s2 = A_MAX[ACC_BITS-1:0];
    end else if (sum < A_MIN) begin
      s2 = A_MIN[ACC_BITS-1:0];
    end else begin
      s2 = sum[ACC_BITS-1:0];
    end
  end

  // clamp to the 32-bit result range
  assign s2_ext = OW'(s2);
  always_comb begin
    if (s2_ext > O_MAX) begin
      result = O_MAX[OUT_BITS-1:0];
    end else if (s2_ext < O_MIN) begin
      result = O_MIN[OUT_BITS-1:0];
    end else begin
      result = s2_ext[OUT_BITS-1:0];
    end
  end

  // stage-two state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_s1_r <= '0;
      acc_r     <= '0;
    end else if (go) begin
      prev_s1_r <= stage_one;
      acc_r     <= s2;
    end
  end

endmodule

FILE: hdl/two_stage_phase_unwrapper.sv
// Top level of the two-stage phase unwrapper: config registers and queues.
// Depends on pup_pkg, pup_front, pup_fifo and pup_back.
//
// Usage:
// - Input channel: an item (in_phase_code, in_first_sample) transfers on a
//   clock edge with in_push high and in_full low.
// - Result channel: out_unwrapped_phase holds the oldest result while
//   out_empty is low; it transfers on an edge with out_pop high.
// - Config channel: cfg_ready is always high; index 0 writes the full-turn
//   threshold, index 1 the half-turn threshold. Write only while idle.
// - An item is registered in the mid queue, then the back stage writes it to
//   the output queue. Throughput: one item per cycle while out_pop keeps up,
//   as front stage, back stage and output queue each take one item per clock.
// - Stall: a two-entry queue sits between front and back, another at the
//   output; when the receiver holds off popping both fill and in_full rises
//   once four items are held.
// - Reset: thresholds return to 3072 and 1024, all unwrap state is zero
//   and both queues empty.
module two_stage_phase_unwrapper
  import pup_pkg::*;
#(
  parameter int PHASE_BITS = 12,
  parameter int ACC_BITS   = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [PHASE_BITS-1:0]      in_phase_code,
  input  logic                       in_first_sample,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic signed [OUT_BITS-1:0] out_unwrapped_phase,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [THR_BITS-1:0]        cfg_data
);

  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 2;
  localparam int MID_W     = ACC_BITS + 1;

  pup_cfg_t                   cfg_r, cfg_nxt;
  logic                       in_acc;
  logic signed [ACC_BITS-1:0] front_s1;
  logic [MID_W-1:0]           mid_wdata;
  logic [MID_W-1:0]           mid_rdata;
  logic                       mid_empty;
  logic                       out_q_full;
  logic                       back_go;
  logic signed [OUT_BITS-1:0] back_result;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_WIDE_THR:   cfg_nxt.wide_thr   = cfg_data;
        REG_NARROW_THR: cfg_nxt.narrow_thr = cfg_data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wide_thr   <= WIDE_THR_RST;
      cfg_r.narrow_thr <= NARROW_THR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: mirror and full-turn stage
  assign in_acc = in_push && !in_full;

  pup_front #(
    .PHASE_BITS (PHASE_BITS),
    .ACC_BITS   (ACC_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_acc),
    .phase_code   (in_phase_code),
    .first_sample (in_first_sample),
    .wide_thr     (cfg_r.wide_thr),
    .stage_one    (front_s1)
  );

  // queue between front and back
  assign mid_wdata = {in_first_sample, front_s1};

  pup_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data (mid_wdata),
    .full      (in_full),
    .pop       (back_go),
    .pop_data  (mid_rdata),
    .empty     (mid_empty)
  );

  // back: half-turn stage, runs whenever an item waits and the output has room
  assign back_go = !mid_empty && !out_q_full;

  pup_back #(
    .PHASE_BITS (PHASE_BITS),
    .ACC_BITS   (ACC_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .go           (back_go),
    .stage_one    (mid_rdata[ACC_BITS-1:0]),
    .first_sample (mid_rdata[ACC_BITS]),
    .narrow_thr   (cfg_r.narrow_thr),
    .result       (back_result)
  );

  // result queue
  pup_fifo #(
    .WIDTH (OUT_BITS),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (back_go),
    .push_data (back_result),
    .full      (out_q_full),
    .pop       (out_pop),
    .pop_data  (out_unwrapped_phase),
    .empty     (out_empty)
  );

endmodule
